>>> rtl/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// Shared types, codes and constants of the MIPS subset instruction executor.
// ----------------------------------------------------------------------------
package msie_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_IDX_W = 5;

    localparam logic [XLEN-1:0] START_PC_RESET = 32'h0000_0000;
    localparam logic [XLEN-1:0] HALT_WORD      = 32'hFFFF_FFFF;
    localparam logic [XLEN-1:0] PC_STEP        = 32'd4;

    localparam int unsigned QUEUE_DEPTH_DEFAULT  = 4;
    localparam int unsigned RESULT_DEPTH_DEFAULT = 2;

    // Primary opcodes.
    localparam logic [5:0] OPC_RTYPE = 6'd0;
    localparam logic [5:0] OPC_J     = 6'd2;
    localparam logic [5:0] OPC_BEQ   = 6'd4;
    localparam logic [5:0] OPC_BNE   = 6'd5;
    localparam logic [5:0] OPC_ADDI  = 6'd8;
    localparam logic [5:0] OPC_SLTI  = 6'd10;
    localparam logic [5:0] OPC_NOP   = 6'd63;

    // R-type function codes.
    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_SLT = 6'd42;

    // Operation selector of an input request.
    localparam logic OP_EXECUTE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_EXECUTED  = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_HALT_NOW  = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    // Instruction class found by the front end.
    typedef enum logic [3:0] {
        K_RESTART = 4'd0,
        K_HALT    = 4'd1,
        K_RTYPE   = 4'd2,
        K_ADDI    = 4'd3,
        K_SLTI    = 4'd4,
        K_BEQ     = 4'd5,
        K_BNE     = 4'd6,
        K_JUMP    = 4'd7,
        K_NOP     = 4'd8,
        K_UNKNOWN = 4'd9
    } t_kind;

    typedef struct packed {
        logic            operation;
        logic [XLEN-1:0] instruction;
        logic [4:0]      read_index;
    } t_in_item;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        t_status         status;
        logic            wrote_register;
        logic [4:0]      dest_index;
        logic [XLEN-1:0] dest_value;
        logic [XLEN-1:0] read_value;
    } t_out_item;

    // Decoded request handed from the front end to the back end.
    typedef struct packed {
        t_kind           kind;
        logic [4:0]      rs;
        logic [4:0]      rt;
        logic [4:0]      rd;
        logic [4:0]      shamt;
        logic [5:0]      funct;
        logic [XLEN-1:0] imm;
        logic [25:0]     target;
        logic [4:0]      read_index;
    } t_dec;

    // Split an instruction word into its fields and classify it.
    function automatic t_dec classify(input t_in_item item);
        t_dec       d;
        logic [5:0] opc;
        opc          = item.instruction[31:26];
        d.rs         = item.instruction[25:21];
        d.rt         = item.instruction[20:16];
        d.rd         = item.instruction[15:11];
        d.shamt      = item.instruction[10:6];
        d.funct      = item.instruction[5:0];
        d.imm        = {{16{item.instruction[15]}}, item.instruction[15:0]};
        d.target     = item.instruction[25:0];
        d.read_index = item.read_index;
        if (item.operation == OP_RESTART) begin
            d.kind = K_RESTART;
        end else if (item.instruction == HALT_WORD) begin
            d.kind = K_HALT;
        end else begin
            case (opc)
                OPC_RTYPE: d.kind = K_RTYPE;
                OPC_ADDI:  d.kind = K_ADDI;
                OPC_SLTI:  d.kind = K_SLTI;
                OPC_BEQ:   d.kind = K_BEQ;
                OPC_BNE:   d.kind = K_BNE;
                OPC_J:     d.kind = K_JUMP;
                OPC_NOP:   d.kind = K_NOP;
                default:   d.kind = K_UNKNOWN;
            endcase
        end
        return d;
    endfunction

endpackage

>>> rtl/msie_ram.sv
// ----------------------------------------------------------------------------
// msie_ram
// Generic RAM: one write port and NREAD read ports, read data registered.
// ----------------------------------------------------------------------------
module msie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned NREAD = 1,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr [NREAD],
    output logic [WIDTH-1:0] o_rdata [NREAD]
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports; a read at the written address returns old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            for (int p = 0; p < NREAD; p++) begin
                o_rdata[p] <= r_mem[i_raddr[p]];
            end
        end
    end

endmodule

>>> rtl/msie_fifo.sv
// ----------------------------------------------------------------------------
// msie_fifo
// Small register-based first-in first-out queue with a combinational head.
// ----------------------------------------------------------------------------
module msie_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/msie_front.sv
// ----------------------------------------------------------------------------
// msie_front
// Front end: accepts input requests, classifies them and hands them to the
// decoupling queue.
// ----------------------------------------------------------------------------
module msie_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  msie_pkg::t_in_item i_item,
    output logic               o_full,
    output logic               o_q_push,
    output msie_pkg::t_dec     o_q_data,
    input  logic               i_q_full
);

    logic           r_valid;
    msie_pkg::t_dec r_dec;
    logic           take;

    // The stage frees up whenever its request moves into the queue.
    assign o_q_push = r_valid;
    assign o_q_data = r_dec;
    assign o_full   = r_valid && i_q_full;
    assign take     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    // Decoded request register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dec <= msie_pkg::classify(i_item);
        end
    end

endmodule

>>> rtl/msie_back.sv
// ----------------------------------------------------------------------------
// msie_back
// Back end: reads the register file, executes one decoded request per cycle
// unless the result queue is full, updates PC and halt flag, pushes the result.
// ----------------------------------------------------------------------------
module msie_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_start_pc,
    input  logic                  i_q_empty,
    input  msie_pkg::t_dec        i_q_data,
    output logic                  o_q_pop,
    input  logic                  i_out_full,
    output logic                  o_out_push,
    output msie_pkg::t_out_item   o_out_data
);

    localparam int unsigned DEPTH = msie_pkg::REG_COUNT;
    localparam int unsigned AW    = msie_pkg::REG_IDX_W;

    // Execute stage and architectural state.
    logic              r_s_valid;
    msie_pkg::t_dec    r_s;
    logic [31:0]       r_pc, n_pc;
    logic              r_halted, n_halted;
    logic [DEPTH-1:0]  r_written;
    logic              r_va, r_vb, r_vr;
    logic              r_lw_valid;
    logic [AW-1:0]     r_lw_idx;
    logic [31:0]       r_lw_val;

    logic              commit;
    logic              pop;
    logic [AW-1:0]     ops_addr [2];
    logic [31:0]       ops_data [2];
    logic [AW-1:0]     rd_addr  [1];
    logic [31:0]       rd_data  [1];

    logic [31:0]       a, b, rv;
    logic [31:0]       pc4, br_target;
    logic              wr, wr_eff;
    logic [AW-1:0]     dix;
    logic [31:0]       dval;
    msie_pkg::t_status status;

    // Newest write wins over data read before it landed; unwritten reads zero.
    function automatic logic [31:0] fwd(input logic [AW-1:0] idx,
                                        input logic [31:0]   ram_val,
                                        input logic          written,
                                        input logic          lw_valid,
                                        input logic [AW-1:0] lw_idx,
                                        input logic [31:0]   lw_val);
        logic [31:0] v;
        if (lw_valid && lw_idx == idx) begin
            v = lw_val;
        end else if (written) begin
            v = ram_val;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign commit     = r_s_valid && !i_out_full;
    assign pop        = !i_q_empty && (!r_s_valid || commit);
    assign o_q_pop    = pop;
    assign o_out_push = commit;

    assign ops_addr[0] = i_q_data.rs;
    assign ops_addr[1] = i_q_data.rt;
    assign rd_addr[0]  = i_q_data.read_index;

    // Operand copy of the register file.
    msie_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .NREAD (2)
    ) u_ram_ops (
        .i_clk   (i_clk),
        .i_we    (commit && wr_eff),
        .i_waddr (dix),
        .i_wdata (dval),
        .i_re    (pop),
        .i_raddr (ops_addr),
        .o_rdata (ops_data)
    );

    // Report copy of the register file.
    msie_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .NREAD (1)
    ) u_ram_rd (
        .i_clk   (i_clk),
        .i_we    (commit && wr_eff),
        .i_waddr (dix),
        .i_wdata (dval),
        .i_re    (pop),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Execute.
    always_comb begin
        a = fwd(r_s.rs, ops_data[0], r_va, r_lw_valid, r_lw_idx, r_lw_val);
        b = fwd(r_s.rt, ops_data[1], r_vb, r_lw_valid, r_lw_idx, r_lw_val);
        rv = fwd(r_s.read_index, rd_data[0], r_vr, r_lw_valid, r_lw_idx, r_lw_val);
        pc4       = r_pc + msie_pkg::PC_STEP;
        br_target = pc4 + {r_s.imm[29:0], 2'b00};
        status    = msie_pkg::ST_EXECUTED;
        wr        = 1'b0;
        dix       = '0;
        dval      = '0;
        n_pc      = pc4;
        n_halted  = r_halted;

        if (r_s.kind == msie_pkg::K_RESTART) begin
            n_pc     = i_start_pc;
            n_halted = 1'b0;
        end else if (r_halted) begin
            status = msie_pkg::ST_IGNORED;
            n_pc   = r_pc;
        end else begin
            case (r_s.kind)
                msie_pkg::K_HALT: begin
                    status   = msie_pkg::ST_HALT_NOW;
                    n_halted = 1'b1;
                end
                msie_pkg::K_RTYPE: begin
                    dix = r_s.rd;
                    wr  = 1'b1;
                    case (r_s.funct)
                        msie_pkg::FN_ADD: dval = a + b;
                        msie_pkg::FN_SUB: dval = a - b;
                        msie_pkg::FN_SLL: dval = b << r_s.shamt;
                        msie_pkg::FN_SRL: dval = b >> r_s.shamt;
                        msie_pkg::FN_SLT: dval = {31'd0, $signed(a) < $signed(b)};
                        default:          wr   = 1'b0;
                    endcase
                end
                msie_pkg::K_ADDI: begin
                    dix  = r_s.rt;
                    wr   = 1'b1;
                    dval = a + r_s.imm;
                end
                msie_pkg::K_SLTI: begin
                    dix  = r_s.rt;
                    wr   = 1'b1;
                    dval = {31'd0, $signed(a) < $signed(r_s.imm)};
                end
                msie_pkg::K_BEQ: begin
                    if (a == b) begin
                        n_pc = br_target;
                    end
                end
                msie_pkg::K_BNE: begin
                    if (a != b) begin
                        n_pc = br_target;
                    end
                end
                msie_pkg::K_JUMP: begin
                    n_pc = {pc4[31:28], r_s.target, 2'b00};
                end
                msie_pkg::K_NOP: begin
                    n_pc = pc4;
                end
                default: begin
                    status = msie_pkg::ST_UNKNOWN;
                end
            endcase
        end

        // Register zero is never written.
        wr_eff = wr && (dix != '0);
        if (!wr_eff) begin
            dix  = '0;
            dval = '0;
        end

        o_out_data.next_pc        = n_pc;
        o_out_data.status         = status;
        o_out_data.wrote_register = wr_eff;
        o_out_data.dest_index     = dix;
        o_out_data.dest_value     = dval;
        o_out_data.read_value     = (wr_eff && dix == r_s.read_index) ? dval : rv;
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid  <= 1'b0;
            r_pc       <= msie_pkg::START_PC_RESET;
            r_halted   <= 1'b0;
            r_written  <= '0;
            r_lw_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s_valid <= 1'b1;
            end else if (commit) begin
                r_s_valid <= 1'b0;
            end
            if (commit) begin
                r_pc     <= n_pc;
                r_halted <= n_halted;
                if (wr_eff) begin
                    r_written[dix] <= 1'b1;
                    r_lw_valid     <= 1'b1;
                end
            end
        end
    end

    // Stage payload, written-flags sampled with the read, last write.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s  <= i_q_data;
            r_va <= r_written[i_q_data.rs];
            r_vb <= r_written[i_q_data.rt];
            r_vr <= r_written[i_q_data.read_index];
        end
        if (commit && wr_eff) begin
            r_lw_idx <= dix;
            r_lw_val <= dval;
        end
    end

endmodule

>>> rtl/mips_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// Executes one MIPS subset instruction word per request against 32 general
// registers and a program counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_item and raise push; the request is taken on a clock
//   edge where push is high and full is low. Each request either executes
//   the instruction word at the current PC or restarts at the start address.
//   Result queue: while empty is low, o_result holds the oldest result; raise
//   pop to take it. Every request yields exactly one result, in order.
//   Configuration: i_cfg_we writes i_cfg_wdata into the start address
//   register; write it only while no request is in flight.
//   Throughput is one request per cycle while the result queue has room: the
//   register file is read from a queue head as the request is popped, and the
//   newest write is forwarded into execute.
//   When the receiver stops popping, the result queue, the execute stage, the
//   decoupling queue and the front register fill in turn before full rises.
//   Reset clears all registers to zero, the PC to zero and the halt flag, and
//   empties both queues; the start address resets to zero.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor #(
    parameter int unsigned QUEUE_DEPTH  = msie_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int unsigned RESULT_DEPTH = msie_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  msie_pkg::t_in_item  i_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output msie_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    localparam int unsigned DEC_W = $bits(msie_pkg::t_dec);
    localparam int unsigned OUT_W = $bits(msie_pkg::t_out_item);

    logic [31:0]         r_start_addr;
    logic                fq_push, fq_full, fq_pop, fq_empty;
    msie_pkg::t_dec      fq_in, fq_out;
    logic                rq_push, rq_full;
    msie_pkg::t_out_item rq_in;

    // Start address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= msie_pkg::START_PC_RESET;
        end else begin
            if (i_cfg_we) begin
                r_start_addr <= i_cfg_wdata;
            end
        end
    end

    msie_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_push (fq_push),
        .o_q_data (fq_in),
        .i_q_full (fq_full)
    );

    // Decoupling queue between decode and execute.
    msie_fifo #(
        .WIDTH (DEC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_dec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_in),
        .o_full  (fq_full),
        .i_pop   (fq_pop),
        .o_empty (fq_empty),
        .o_data  (fq_out)
    );

    msie_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start_pc (r_start_addr),
        .i_q_empty  (fq_empty),
        .i_q_data   (fq_out),
        .o_q_pop    (fq_pop),
        .i_out_full (rq_full),
        .o_out_push (rq_push),
        .o_out_data (rq_in)
    );

    // Result queue toward the receiver.
    msie_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

>>> tb/sv/tb_mips_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// tb_mips_subset_instruction_executor
// Self-checking bench for the MIPS subset executor. An in-bench model keeps
// its own register file, PC, halt flag and start address. It predicts every
// result when a request is accepted, and a receiver process compares each
// popped result field by field. Directed programs cover the arithmetic, the
// control flow and the halt corner cases. They are followed by random
// programs under several start addresses and idle patterns, and by a long
// receiver stall that fills the block.
// ----------------------------------------------------------------------------
module tb_mips_subset_instruction_executor;

    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    msie_pkg::t_in_item  i_item;
    logic                full;
    logic                pop;
    logic                empty;
    msie_pkg::t_out_item o_result;
    logic                i_cfg_we;
    logic [31:0]         i_cfg_wdata;

    // Model state of the core.
    logic [31:0] gpr_q [msie_pkg::REG_COUNT];
    logic [31:0] pc_q;
    logic        halted_q;
    logic [31:0] start_pc_q;

    msie_pkg::t_out_item pending_results[$];
    int unsigned         mismatches;
    bit                  send_idle_on;
    bit                  recv_idle_on;
    int unsigned         receiver_hold;

    mips_subset_instruction_executor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Instruction encoders in assembler operand order.
    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs,
                                          logic [4:0] rt, logic [4:0] sh);
        return {msie_pkg::OPC_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] opc, logic [4:0] rt, logic [4:0] rs,
                                          logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(logic [25:0] target);
        return {msie_pkg::OPC_J, target};
    endfunction

    // Execute one request on the model state and return the result it yields.
    function automatic msie_pkg::t_out_item predict_execution(msie_pkg::t_in_item req);
        msie_pkg::t_out_item res;
        msie_pkg::t_status   st;
        logic [31:0] word;
        logic [31:0] pc_plus4;
        logic [31:0] pc_next;
        logic [31:0] imm_ext;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] wr_value;
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [4:0]  wr_index;
        logic        wr_en;
        word     = req.instruction;
        st       = msie_pkg::ST_EXECUTED;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_value = '0;
        if (req.operation == msie_pkg::OP_RESTART) begin
            pc_q     = start_pc_q;
            halted_q = 1'b0;
        end else if (halted_q) begin
            st = msie_pkg::ST_IGNORED;
        end else begin
            opc      = word[31:26];
            rs       = word[25:21];
            rt       = word[20:16];
            rd       = word[15:11];
            sh       = word[10:6];
            fn       = word[5:0];
            imm_ext  = {{16{word[15]}}, word[15:0]};
            op_a     = gpr_q[rs];
            op_b     = gpr_q[rt];
            pc_plus4 = pc_q + msie_pkg::PC_STEP;
            pc_next  = pc_plus4;
            if (word == msie_pkg::HALT_WORD) begin
                st       = msie_pkg::ST_HALT_NOW;
                halted_q = 1'b1;
            end else begin
                case (opc)
                    msie_pkg::OPC_RTYPE: begin
                        wr_index = rd;
                        wr_en    = 1'b1;
                        case (fn)
                            msie_pkg::FN_ADD: wr_value = op_a + op_b;
                            msie_pkg::FN_SUB: wr_value = op_a - op_b;
                            msie_pkg::FN_SLL: wr_value = op_b << sh;
                            msie_pkg::FN_SRL: wr_value = op_b >> sh;
                            msie_pkg::FN_SLT:
                                wr_value = ($signed(op_a) < $signed(op_b)) ? 32'd1 : 32'd0;
                            default: wr_en = 1'b0;
                        endcase
                    end
                    msie_pkg::OPC_ADDI: begin
                        wr_index = rt;
                        wr_en    = 1'b1;
                        wr_value = op_a + imm_ext;
                    end
                    msie_pkg::OPC_SLTI: begin
                        wr_index = rt;
                        wr_en    = 1'b1;
                        wr_value = ($signed(op_a) < $signed(imm_ext)) ? 32'd1 : 32'd0;
                    end
                    msie_pkg::OPC_BEQ: begin
                        if (op_a == op_b) pc_next = pc_plus4 + (imm_ext << 2);
                    end
                    msie_pkg::OPC_BNE: begin
                        if (op_a != op_b) pc_next = pc_plus4 + (imm_ext << 2);
                    end
                    msie_pkg::OPC_J: begin
                        pc_next = {pc_plus4[31:28], word[25:0], 2'b00};
                    end
                    msie_pkg::OPC_NOP: begin
                    end
                    default: begin
                        st = msie_pkg::ST_UNKNOWN;
                    end
                endcase
            end
            // Register zero is hard-wired, so a write to it is dropped.
            if (wr_en && wr_index == 5'd0) wr_en = 1'b0;
            if (wr_en) begin
                gpr_q[wr_index] = wr_value;
            end else begin
                wr_index = '0;
                wr_value = '0;
            end
            pc_q = pc_next;
        end
        res.next_pc        = pc_q;
        res.status         = st;
        res.wrote_register = wr_en;
        res.dest_index     = wr_index;
        res.dest_value     = wr_value;
        res.read_value     = gpr_q[req.read_index];
        return res;
    endfunction

    // Offer one request after a random gap and predict it once accepted.
    task automatic send_request(logic operation, logic [31:0] word, logic [4:0] ridx);
        msie_pkg::t_in_item  req;
        msie_pkg::t_out_item expected;
        int unsigned gap;
        req.operation   = operation;
        req.instruction = word;
        req.read_index  = ridx;
        gap = send_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        expected = predict_execution(req);
        pending_results.insert(pending_results.size(), expected);
    endtask

    task automatic send_exec(logic [31:0] word, logic [4:0] ridx);
        send_request(msie_pkg::OP_EXECUTE, word, ridx);
    endtask

    task automatic send_restart(logic [31:0] word, logic [4:0] ridx);
        send_request(msie_pkg::OP_RESTART, word, ridx);
    endtask

    // Stop offering requests and wait until every result has been popped.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start_pc(logic [31:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        start_pc_q  = value;
    endtask

    function automatic logic [4:0] random_reg();
        // Mostly a small pool so that results feed the next instructions.
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [15:0] random_imm();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(0, 8));
            5:       return 16'hFFFF - 16'($urandom_range(0, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] unknown_opcode();
        case ($urandom_range(0, 5))
            0:       return 6'd1;
            1:       return 6'd3;
            2:       return 6'd6;
            3:       return 6'd7;
            4:       return 6'd9;
            default: return 6'($urandom_range(11, 62));
        endcase
    endfunction

    // Mostly well-formed instructions with random operands, some noise.
    function automatic logic [31:0] random_instruction();
        int unsigned pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        pick = $urandom_range(0, 99);
        rs   = random_reg();
        rt   = random_reg();
        rd   = random_reg();
        sh   = 5'($urandom);
        if (pick < 12) return enc_r(msie_pkg::FN_ADD, rd, rs, rt, sh);
        if (pick < 22) return enc_r(msie_pkg::FN_SUB, rd, rs, rt, sh);
        if (pick < 30) return enc_r(msie_pkg::FN_SLL, rd, rs, rt, sh);
        if (pick < 38) return enc_r(msie_pkg::FN_SRL, rd, rs, rt, sh);
        if (pick < 46) return enc_r(msie_pkg::FN_SLT, rd, rs, rt, sh);
        if (pick < 60) return enc_i(msie_pkg::OPC_ADDI, rt, rs, random_imm());
        if (pick < 68) return enc_i(msie_pkg::OPC_SLTI, rt, rs, random_imm());
        if (pick < 76) return enc_i(msie_pkg::OPC_BEQ, ($urandom_range(0, 1) ? rs : rt), rs,
                                    random_imm());
        if (pick < 84) return enc_i(msie_pkg::OPC_BNE, ($urandom_range(0, 1) ? rs : rt), rs,
                                    random_imm());
        if (pick < 89) return enc_j(26'($urandom));
        if (pick < 91) return {msie_pkg::OPC_NOP, 26'($urandom)};
        if (pick < 93) return enc_r(6'($urandom), rd, rs, rt, sh);
        if (pick < 95) return {unknown_opcode(), 26'($urandom)};
        if (pick < 97) return $urandom;
        return msie_pkg::HALT_WORD;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    // Receiver: random stalls, an optional long hold, and a check per result.
    initial begin
        msie_pkg::t_out_item want;
        int unsigned         stall;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (receiver_hold > 0) begin
                stall         = receiver_hold;
                receiver_hold = 0;
            end else begin
                stall = recv_idle_on ? $urandom_range(0, 5) : 0;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request pending: %p", $realtime, o_result);
            end else begin
                want = pending_results.pop_front();
                compare_field("next_pc", want.next_pc, o_result.next_pc);
                compare_field("status", 32'(want.status), 32'(o_result.status));
                compare_field("wrote_register", 32'(want.wrote_register),
                              32'(o_result.wrote_register));
                compare_field("dest_index", 32'(want.dest_index), 32'(o_result.dest_index));
                compare_field("dest_value", want.dest_value, o_result.dest_value);
                compare_field("read_value", want.read_value, o_result.read_value);
            end
        end
    end

    // Arithmetic, shifts, compares, register zero and the odd opcodes.
    task automatic test_alu_directed();
        send_exec(enc_i(msie_pkg::OPC_ADDI, 5'd1, 5'd0, 16'h7FFF), 5'd1);
        send_exec(enc_i(msie_pkg::OPC_ADDI, 5'd2, 5'd0, 16'h8000), 5'd2);
        send_exec(enc_i(msie_pkg::OPC_ADDI, 5'd0, 5'd1, 16'h0005), 5'd0);
        send_exec(enc_i(msie_pkg::OPC_ADDI, 5'd31, 5'd0, 16'hFFFF), 5'd31);
        // A logical right shift of all ones gives the largest positive value.
        send_exec(enc_r(msie_pkg::FN_SRL, 5'd5, 5'd0, 5'd31, 5'd1), 5'd5);
        send_exec(enc_r(msie_pkg::FN_ADD, 5'd6, 5'd5, 5'd5, 5'd0), 5'd6);
        send_exec(enc_r(msie_pkg::FN_SUB, 5'd7, 5'd0, 5'd31, 5'd0), 5'd7);
        send_exec(enc_r(msie_pkg::FN_SLL, 5'd8, 5'd0, 5'd31, 5'd31), 5'd8);
        send_exec(enc_r(msie_pkg::FN_SRL, 5'd9, 5'd0, 5'd8, 5'd31), 5'd9);
        send_exec(enc_r(msie_pkg::FN_SLT, 5'd11, 5'd8, 5'd7, 5'd0), 5'd11);
        send_exec(enc_r(msie_pkg::FN_SLT, 5'd12, 5'd7, 5'd8, 5'd0), 5'd12);
        send_exec(enc_i(msie_pkg::OPC_SLTI, 5'd13, 5'd31, 16'h0000), 5'd13);
        send_exec(enc_i(msie_pkg::OPC_SLTI, 5'd14, 5'd5, 16'h8000), 5'd14);
        send_exec(enc_r(6'h3F, 5'd15, 5'd31, 5'd31, 5'd3), 5'd15);
        send_exec({msie_pkg::OPC_NOP, 26'h000_1234}, 5'd31);
        send_exec({6'd3, 26'h3FF_FFFF}, 5'd1);
        send_exec(enc_r(msie_pkg::FN_ADD, 5'd0, 5'd31, 5'd31, 5'd0), 5'd0);
    endtask

    // Jumps and branches across the address wrap, halt and restart.
    task automatic test_flow_directed();
        write_start_pc(32'hF000_0000);
        send_restart(32'h0, 5'd31);
        send_exec(enc_j(26'h3FF_FFFF), 5'd0);
        send_exec(enc_j(26'h000_0000), 5'd0);
        send_exec(enc_i(msie_pkg::OPC_BEQ, 5'd0, 5'd0, 16'hFFFE), 5'd0);
        send_exec(enc_i(msie_pkg::OPC_BEQ, 5'd0, 5'd0, 16'h0000), 5'd0);
        send_exec(enc_i(msie_pkg::OPC_BNE, 5'd0, 5'd31, 16'h7FFF), 5'd31);
        send_exec(enc_i(msie_pkg::OPC_BNE, 5'd0, 5'd0, 16'h1234), 5'd0);
        send_exec(enc_i(msie_pkg::OPC_BEQ, 5'd31, 5'd7, 16'h0010), 5'd7);
        send_exec(msie_pkg::HALT_WORD, 5'd1);
        // While halted, nothing changes, not even for another halt word.
        send_exec(enc_i(msie_pkg::OPC_ADDI, 5'd1, 5'd0, 16'h0001), 5'd1);
        send_exec(msie_pkg::HALT_WORD, 5'd1);
        send_restart(msie_pkg::HALT_WORD, 5'd1);
        write_start_pc(32'hFFFF_FFFF);
        send_restart(32'h0, 5'd2);
        send_exec(enc_i(msie_pkg::OPC_ADDI, 5'd2, 5'd2, 16'h0001), 5'd2);
    endtask

    // Random programs from one start address; ignored requests do not count.
    task automatic test_random_programs(int unsigned count, logic [31:0] start,
                                        bit send_idle, bit recv_idle);
        int unsigned done;
        bit          was_halted;
        write_start_pc(start);
        send_idle_on = send_idle;
        recv_idle_on = recv_idle;
        done = 0;
        while (done < count) begin
            was_halted = halted_q;
            if ((was_halted && $urandom_range(0, 1) == 1) || $urandom_range(0, 39) == 0) begin
                send_restart($urandom, 5'($urandom));
                done++;
            end else begin
                send_exec(random_instruction(), 5'($urandom));
                if (!was_halted) done++;
            end
        end
    endtask

    // The receiver holds off while requests keep coming, so the block fills.
    task automatic test_backpressure();
        wait_idle();
        send_idle_on  = 1'b0;
        recv_idle_on  = 1'b0;
        receiver_hold = 80;
        repeat (40) send_exec(random_instruction(), 5'($urandom));
        wait_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_item        <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        mismatches    = 0;
        receiver_hold = 0;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        foreach (gpr_q[i]) gpr_q[i] = '0;
        pc_q       = msie_pkg::START_PC_RESET;
        halted_q   = 1'b0;
        start_pc_q = msie_pkg::START_PC_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_alu_directed();
        test_flow_directed();
        test_random_programs(135, 32'h0000_0000, 1'b1, 1'b1);
        test_random_programs(135, $urandom, 1'b0, 1'b0);
        test_backpressure();
        test_random_programs(135, 32'hFFFF_FFFF, 1'b1, 1'b0);
        test_random_programs(115, 32'h8000_0000, 1'b0, 1'b1);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
